### sv/sle_pkg.sv
// Package with character codes, register indexes and shared types of the serial line editor.
package sle_pkg;

   localparam int CHAR_W = 8;
   localparam int COUNT_W = 8;
   localparam int MODE_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam int ECHO_DEPTH = 3;
   localparam int NUM_W = 2;

   localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
   localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;
   localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
   localparam logic [CHAR_W-1:0] CH_SP = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

   localparam logic [MODE_W-1:0] MODE_EDIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BELL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SIMPLE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SIMPLE_ALT = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHARS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDIT_MODE = 1'b1;

   localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 8'd63;
   localparam logic [MODE_W-1:0] EDIT_MODE_RESET = MODE_EDIT;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [ECHO_DEPTH-1:0][CHAR_W-1:0] echo;
      logic store_valid;
      logic [COUNT_W-1:0] store_index;
      logic [CHAR_W-1:0] store_char;
      logic line_done;
      logic [COUNT_W-1:0] line_length;
   } result_set_type;

endpackage

### sv/sle_if.sv
// Word channel interfaces for received characters and for echo results.
interface sle_req_if;
   logic valid;
   logic ready;
   logic [7:0] in_char;

   modport source (output valid, output in_char, input ready);
   modport sink (input valid, input in_char, output ready);
endinterface

interface sle_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] echo_char;
   logic last;
   logic store_valid;
   logic [7:0] store_index;
   logic [7:0] store_char;
   logic line_done;
   logic [7:0] line_length;

   modport source (output valid, output echo_char, output last, output store_valid,
                   output store_index, output store_char, output line_done,
                   output line_length, input ready);
   modport sink (input valid, input echo_char, input last, input store_valid,
                 input store_index, input store_char, input line_done,
                 input line_length, output ready);
endinterface

### sv/sle_decode.sv
// Decoder that turns one character and the line count into its echo words and next count.
module sle_decode (
   input logic [sle_pkg::CHAR_W-1:0] in_char,
   input logic [sle_pkg::COUNT_W-1:0] char_count,
   input logic [sle_pkg::COUNT_W-1:0] max_chars,
   input logic [sle_pkg::MODE_W-1:0] edit_mode,
   output sle_pkg::result_set_type result_set,
   output logic [sle_pkg::COUNT_W-1:0] next_count
);
   import sle_pkg::*;

   logic is_erase;
   logic is_eol;
   logic is_simple;
   logic at_limit;

   assign is_erase = (in_char == CH_BS) || (in_char == CH_DEL);
   assign is_eol = (in_char == CH_CR) || (in_char == CH_LF);
   assign is_simple = (edit_mode == MODE_SIMPLE) || (edit_mode == MODE_SIMPLE_ALT);
   assign at_limit = char_count >= max_chars;

   always_comb begin
      result_set = '0;
      next_count = char_count;
      priority if (is_simple) begin
         result_set.num = 2'd1;
         result_set.echo[0] = in_char;
         result_set.store_valid = 1'b1;
         result_set.store_index = char_count;
         if (is_eol || at_limit) begin
            result_set.store_char = CH_NUL;
            result_set.line_done = 1'b1;
            result_set.line_length = char_count;
            next_count = '0;
         end else begin
            result_set.store_char = in_char;
            next_count = char_count + 8'd1;
         end
      end else if (is_erase) begin
         if (edit_mode == MODE_BELL) begin
            result_set.num = 2'd1;
            result_set.echo[0] = CH_BEL;
         end else if (char_count != '0) begin
            result_set.num = 2'd3;
            result_set.echo[0] = CH_BS;
            result_set.echo[1] = CH_SP;
            result_set.echo[2] = CH_BS;
            next_count = char_count - 8'd1;
         end
      end else if (is_eol) begin
         result_set.num = 2'd2;
         result_set.echo[0] = CH_CR;
         result_set.echo[1] = CH_LF;
         result_set.store_valid = 1'b1;
         result_set.store_index = char_count;
         result_set.store_char = CH_NUL;
         result_set.line_done = 1'b1;
         result_set.line_length = char_count;
         next_count = '0;
      end else if (!at_limit) begin
         result_set.num = 2'd1;
         result_set.echo[0] = in_char;
         result_set.store_valid = 1'b1;
         result_set.store_index = char_count;
         result_set.store_char = in_char;
         next_count = char_count + 8'd1;
      end else begin
         result_set.num = 2'd1;
         result_set.echo[0] = CH_BEL;
      end
   end

endmodule

### sv/serial_line_editor_top.sv
// Serial line editor top level: input register, decoder and echo word sequencer.
// An accepted character waits in the input register; it is decoded and registered in the result
// register once that is free, and its first echo word is offered from then on.
// Throughput: one character per cycle when each causes one word and the receiver does not stall;
// a character causing n words holds the result register until all n have moved, one word a cycle.
// Reset clears the line count and valid flags and loads max_chars 63 and edit_mode 0.
module serial_line_editor_top (
   input logic clock,
   input logic reset,
   sle_req_if.sink req_chan,
   sle_rsp_if.source rsp_chan,
   input logic csr_write_enable,
   input logic [sle_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [sle_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import sle_pkg::*;

   logic [COUNT_W-1:0] max_chars_ff;
   logic [MODE_W-1:0] edit_mode_ff;
   logic [COUNT_W-1:0] char_count_ff;
   logic [COUNT_W-1:0] char_count_in;
   logic in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   result_set_type buf_ff;
   result_set_type buf_in;
   logic [NUM_W-1:0] pos_ff;
   logic buf_busy;
   logic buf_last;
   logic buf_free;
   logic move;
   logic req_take;
   logic rsp_take;

   sle_decode u_decode (
      .in_char (in_char_ff),
      .char_count (char_count_ff),
      .max_chars (max_chars_ff),
      .edit_mode (edit_mode_ff),
      .result_set (buf_in),
      .next_count (char_count_in)
   );

   assign buf_busy = buf_ff.num != '0;
   assign buf_last = pos_ff == (buf_ff.num - 2'd1);
   assign rsp_take = buf_busy && rsp_chan.ready;
   assign buf_free = !buf_busy || (rsp_take && buf_last);
   assign move = in_valid_ff && buf_free;
   assign req_chan.ready = !in_valid_ff || move;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
         edit_mode_ff <= EDIT_MODE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_CHARS: max_chars_ff <= csr_write_data[COUNT_W-1:0];
            CSR_EDIT_MODE: edit_mode_ff <= csr_write_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_take) begin
         in_char_ff <= req_chan.in_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         buf_ff.num <= '0;
         pos_ff <= '0;
      end else if (move) begin
         char_count_ff <= char_count_in;
         buf_ff.num <= buf_in.num;
         pos_ff <= '0;
      end else if (rsp_take) begin
         if (buf_last) begin
            buf_ff.num <= '0;
            pos_ff <= '0;
         end else begin
            pos_ff <= pos_ff + 2'd1;
         end
      end
      if (move) begin
         buf_ff.echo <= buf_in.echo;
         buf_ff.store_valid <= buf_in.store_valid;
         buf_ff.store_index <= buf_in.store_index;
         buf_ff.store_char <= buf_in.store_char;
         buf_ff.line_done <= buf_in.line_done;
         buf_ff.line_length <= buf_in.line_length;
      end
   end

   assign rsp_chan.valid = buf_busy;
   assign rsp_chan.echo_char = buf_ff.echo[pos_ff];
   assign rsp_chan.last = buf_last;
   assign rsp_chan.store_valid = buf_last && buf_ff.store_valid;
   assign rsp_chan.store_index = buf_last ? buf_ff.store_index : '0;
   assign rsp_chan.store_char = buf_last ? buf_ff.store_char : '0;
   assign rsp_chan.line_done = buf_last && buf_ff.line_done;
   assign rsp_chan.line_length = buf_last ? buf_ff.line_length : '0;

endmodule

### bench/tb.sv
// Self-checking testbench for the serial line editor: directed characters, random lines, stalls.
`timescale 1ns / 1ps

module tb;
   import sle_pkg::*;

   localparam int PHASES = 10;
   localparam int PHASE_CHARS = 40;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 150;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] echo_char;
      logic last;
      logic store_valid;
      logic [7:0] store_index;
      logic [7:0] store_char;
      logic line_done;
      logic [7:0] line_length;
   } echo_word_type;

   typedef struct packed {
      logic set_cfg;
      logic [7:0] max_chars;
      logic [1:0] mode;
      logic [7:0] ch;
      logic typed;
      logic [1:0] words;
      logic [7:0] e0;
      logic [7:0] e1;
      logic [7:0] e2;
      logic sv;
      logic [7:0] si;
      logic [7:0] sc;
      logic ld;
      logic [7:0] ll;
   } directed_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   sle_req_if req_chan ();
   sle_rsp_if rsp_chan ();

   serial_line_editor_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Fields: set_cfg, max_chars, mode, char, typed, words, echo 0..2, store, done, length.
   directed_char_type directed_chars [25] = '{
      '{0, 8'd0, MODE_EDIT, CH_BS, 1, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, CH_DEL, 1, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, 8'h41, 1, 1, 8'h41, CH_NUL, CH_NUL, 1, 8'd0, 8'h41, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, 8'hFF, 1, 1, 8'hFF, CH_NUL, CH_NUL, 1, 8'd1, 8'hFF, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, 8'h00, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, CH_DEL, 1, 3, CH_BS, CH_SP, CH_BS, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, CH_CR, 1, 2, CH_CR, CH_LF, CH_NUL, 1, 8'd2, CH_NUL, 1, 8'd2},
      '{1, 8'd0, MODE_EDIT, 8'h78, 1, 1, CH_BEL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, CH_LF, 1, 2, CH_CR, CH_LF, CH_NUL, 1, 8'd0, CH_NUL, 1, 8'd0},
      '{1, 8'd2, MODE_BELL, 8'h61, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_BELL, 8'h62, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_BELL, 8'h63, 1, 1, CH_BEL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_BELL, CH_BS, 1, 1, CH_BEL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{1, 8'd1, MODE_BELL, 8'h80, 1, 1, CH_BEL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{1, 8'd1, MODE_EDIT, CH_DEL, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_EDIT, CH_LF, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{1, 8'd255, MODE_SIMPLE, CH_BS, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_SIMPLE, CH_DEL, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_SIMPLE, CH_CR, 1, 1, CH_CR, CH_NUL, CH_NUL, 1, 8'd2, CH_NUL, 1, 8'd2},
      '{1, 8'd1, MODE_SIMPLE_ALT, 8'h71, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{0, 8'd0, MODE_SIMPLE_ALT, 8'h72, 1, 1, 8'h72, CH_NUL, CH_NUL, 1, 8'd1, CH_NUL, 1, 8'd1},
      '{0, 8'd0, MODE_SIMPLE_ALT, CH_LF, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{1, 8'd63, MODE_SIMPLE, 8'h55, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{1, 8'd0, MODE_SIMPLE, 8'hAA, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0},
      '{1, 8'd63, MODE_EDIT, CH_BEL, 0, 0, CH_NUL, CH_NUL, CH_NUL, 0, 8'd0, CH_NUL, 0, 8'd0}
   };

   echo_word_type echo_words [$];
   echo_word_type step_words [ECHO_DEPTH];

   logic [7:0] cfg_max = MAX_CHARS_RESET;
   logic [1:0] cfg_mode = EDIT_MODE_RESET;
   logic [7:0] line_count = 8'd0;

   bit idling = 1'b1;
   int hold_requests = 0;
   int error_count = 0;
   int chars_sent = 0;
   int words_checked = 0;
   int lines_closed = 0;
   int settings_written = 0;
   int quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic void keep_char(input int k, input logic [7:0] c);
      step_words[k].store_valid = 1'b1;
      step_words[k].store_index = line_count;
      step_words[k].store_char = c;
      line_count = line_count + 8'd1;
   endfunction

   function automatic void close_line(input int k);
      step_words[k].store_valid = 1'b1;
      step_words[k].store_index = line_count;
      step_words[k].store_char = CH_NUL;
      step_words[k].line_done = 1'b1;
      step_words[k].line_length = line_count;
      line_count = 8'd0;
   endfunction

   function automatic int edit_step(input logic [7:0] c);
      logic erase;
      logic eol;
      int n;
      erase = (c == CH_BS) || (c == CH_DEL);
      eol = (c == CH_CR) || (c == CH_LF);
      n = 1;
      for (int k = 0; k < ECHO_DEPTH; k++) step_words[k] = '0;
      if (cfg_mode == MODE_SIMPLE || cfg_mode == MODE_SIMPLE_ALT) begin
         step_words[0].echo_char = c;
         if (eol || line_count >= cfg_max) close_line(0);
         else keep_char(0, c);
      end else if (erase) begin
         if (cfg_mode == MODE_BELL) begin
            step_words[0].echo_char = CH_BEL;
         end else if (line_count != 0) begin
            step_words[0].echo_char = CH_BS;
            step_words[1].echo_char = CH_SP;
            step_words[2].echo_char = CH_BS;
            line_count = line_count - 8'd1;
            n = 3;
         end else begin
            n = 0;
         end
      end else if (eol) begin
         step_words[0].echo_char = CH_CR;
         step_words[1].echo_char = CH_LF;
         close_line(1);
         n = 2;
      end else if (line_count < cfg_max) begin
         step_words[0].echo_char = c;
         keep_char(0, c);
      end else begin
         step_words[0].echo_char = CH_BEL;
      end
      if (n > 0) step_words[n-1].last = 1'b1;
      return n;
   endfunction

   function automatic void queue_step(input logic [7:0] c);
      int n;
      n = edit_step(c);
      for (int k = 0; k < n; k++) echo_words.push_back(step_words[k]);
   endfunction

   function automatic logic [7:0] next_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
      if (r < 67) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
      if (r < 75) return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      $display("tb: mismatch in %s at word %0d: got %h, expected %h",
               what, words_checked, got, want);
   endtask

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = idling ? pick_gap() : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_char <= c;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      chars_sent++;
   endtask

   task automatic wait_for_echoes();
      req_chan.valid <= 1'b0;
      while (echo_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] max_chars, input logic [1:0] mode);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MAX_CHARS;
      csr_write_data <= max_chars;
      @(posedge clock);
      csr_index <= CSR_EDIT_MODE;
      csr_write_data <= {6'($urandom_range(0, 63)), mode};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_max = max_chars;
      cfg_mode = mode;
      settings_written++;
   endtask

   // The receiver stalls at random and serves long holds requested by the stimulus.
   initial begin : receiver
      int stall_left;
      int hold_left;
      int holds_done;
      stall_left = 0;
      hold_left = 0;
      holds_done = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            if (holds_done != hold_requests) begin
               holds_done++;
               hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
               hold_left--;
               rsp_chan.ready <= 1'b0;
            end else if (stall_left != 0) begin
               stall_left--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
               if (idling && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin : echo_check
      echo_word_type got;
      echo_word_type want;
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.echo_char = rsp_chan.echo_char;
         got.last = rsp_chan.last;
         got.store_valid = rsp_chan.store_valid;
         got.store_index = rsp_chan.store_index;
         got.store_char = rsp_chan.store_char;
         got.line_done = rsp_chan.line_done;
         got.line_length = rsp_chan.line_length;
         if (echo_words.size() == 0) begin
            report_mismatch("word with nothing expected, echo_char", got.echo_char, 8'h00);
         end else begin
            want = echo_words.pop_front();
            if (got.echo_char !== want.echo_char)
               report_mismatch("echo_char", got.echo_char, want.echo_char);
            if (got.last !== want.last)
               report_mismatch("last", 8'(got.last), 8'(want.last));
            if (got.store_valid !== want.store_valid)
               report_mismatch("store_valid", 8'(got.store_valid), 8'(want.store_valid));
            if (got.store_index !== want.store_index)
               report_mismatch("store_index", got.store_index, want.store_index);
            if (got.store_char !== want.store_char)
               report_mismatch("store_char", got.store_char, want.store_char);
            if (got.line_done !== want.line_done)
               report_mismatch("line_done", 8'(got.line_done), 8'(want.line_done));
            if (got.line_length !== want.line_length)
               report_mismatch("line_length", got.line_length, want.line_length);
            if (want.line_done) lines_closed++;
         end
         words_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: timeout after %0d cycles with no word moving", quiet_cycles);
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      directed_char_type row;
      echo_word_type w;
      logic [7:0] max_pick;
      req_chan.valid = 1'b0;
      req_chan.in_char = 8'h00;
      csr_write_enable = 1'b0;
      csr_index = CSR_MAX_CHARS;
      csr_write_data = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed characters start from the reset settings.
      for (int i = 0; i < $size(directed_chars); i++) begin
         row = directed_chars[i];
         if (row.set_cfg) begin
            wait_for_echoes();
            set_config(row.max_chars, row.mode);
         end
         send_char(row.ch);
         if (row.typed) begin
            void'(edit_step(row.ch));
            for (int k = 0; k < row.words; k++) begin
               w = '0;
               w.echo_char = (k == 0) ? row.e0 : (k == 1) ? row.e1 : row.e2;
               if (k == row.words - 1) begin
                  w.last = 1'b1;
                  w.store_valid = row.sv;
                  w.store_index = row.si;
                  w.store_char = row.sc;
                  w.line_done = row.ld;
                  w.line_length = row.ll;
               end
               echo_words.push_back(w);
            end
         end else begin
            queue_step(row.ch);
         end
      end

      // Random lines under a new setting per phase; the line count carries across phases.
      for (int p = 0; p < PHASES; p++) begin
         wait_for_echoes();
         case (p % 5)
            0: max_pick = 8'd255;
            1: max_pick = 8'd0;
            2: max_pick = 8'd1;
            3: max_pick = 8'($urandom_range(2, 12));
            default: max_pick = 8'($urandom_range(0, 255));
         endcase
         set_config(max_pick, 2'(p % 4));
         idling = (p % 3) != 2;
         if (p == 2) hold_requests <= hold_requests + 1;
         for (int i = 0; i < PHASE_CHARS; i++) begin
            logic [7:0] c;
            c = next_char();
            send_char(c);
            queue_step(c);
            if (idling && $urandom_range(0, 49) == 0) wait_for_echoes();
         end
      end

      wait_for_echoes();
      $display("tb: %0d characters under %0d register settings, %0d echo words, %0d lines",
               chars_sent, settings_written + 1, words_checked, lines_closed);
      $display("tb: edit, bell and simple modes, limits 0 to 255, %0d mismatches", error_count);
      if (error_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
